// ----- src/bls_pkg.sv -----
package bls_pkg;

   // Stack geometry
   localparam int DEPTH = 8;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   // Field widths
   localparam int ACTION_W = 2;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_PUSH    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DISPLAY = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SEARCH  = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // Result register load selects
   localparam int RES_W = 3;
   localparam logic [RES_W-1:0] RES_OK_NONE = 3'd0;  // ok, no data
   localparam logic [RES_W-1:0] RES_OVF     = 3'd1;
   localparam logic [RES_W-1:0] RES_UNDER   = 3'd2;
   localparam logic [RES_W-1:0] RES_DATA    = 3'd3;  // entry read from memory
   localparam logic [RES_W-1:0] RES_HIT     = 3'd4;  // search key found
   localparam logic [RES_W-1:0] RES_MISS    = 3'd5;  // search key not found

   typedef struct packed {
      logic             start;    // latch request, point at top entry
      logic             wr_push;  // write key on top, bump fill level
      logic             pop_dec;  // drop fill level by one
      logic             rd;       // read entry at scan pointer
      logic             step;     // move scan pointer down
      logic             res_load;
      logic [RES_W-1:0] res_sel;
   } bls_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                empty;
      logic                full;
      logic                idx_zero;
      logic                match;
      logic                res_last;
   } bls_stat_type;

endpackage

// ----- src/bls_if.sv -----
interface bls_req_if;
   logic                                valid;
   logic                                ready;
   logic [bls_pkg::ACTION_W-1:0]        action;
   logic signed [bls_pkg::WORD_W-1:0]   value_in;

   modport source (output valid, action, value_in, input ready);
   modport sink   (input valid, action, value_in, output ready);
endinterface

interface bls_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bls_pkg::STATUS_W-1:0]        status;
   logic signed [bls_pkg::WORD_W-1:0]   value_out;
   logic                                found;
   logic                                last;

   modport source (output valid, status, value_out, found, last, input ready);
   modport sink   (input valid, status, value_out, found, last, output ready);
endinterface

// ----- src/bls_ctrl.sv -----
module bls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bls_pkg::bls_stat_type stat,
   output bls_pkg::bls_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.res_load = 1'b1;
            state_in     = S_RESP;
            case (stat.action)
               bls_pkg::ACT_PUSH: begin
                  if (stat.full) begin
                     cmd.res_sel = bls_pkg::RES_OVF;
                  end else begin
                     cmd.wr_push = 1'b1;
                     cmd.res_sel = bls_pkg::RES_OK_NONE;
                  end
               end
               bls_pkg::ACT_POP: begin
                  if (stat.empty) begin
                     cmd.res_sel = bls_pkg::RES_UNDER;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.pop_dec  = 1'b1;
                     cmd.rd       = 1'b1;
                     state_in     = S_FETCH;
                  end
               end
               bls_pkg::ACT_DISPLAY: begin
                  if (stat.empty) begin
                     cmd.res_sel = bls_pkg::RES_UNDER;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.rd       = 1'b1;
                     state_in     = S_FETCH;
                  end
               end
               bls_pkg::ACT_SEARCH: begin
                  if (stat.empty) begin
                     cmd.res_sel = bls_pkg::RES_MISS;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.rd       = 1'b1;
                     state_in     = S_FETCH;
                  end
               end
               default: begin
                  cmd.res_sel = bls_pkg::RES_OK_NONE;
               end
            endcase
         end
         S_FETCH: begin
            if (stat.action == bls_pkg::ACT_SEARCH) begin
               if (stat.match) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = bls_pkg::RES_HIT;
                  state_in     = S_RESP;
               end else if (stat.idx_zero) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = bls_pkg::RES_MISS;
                  state_in     = S_RESP;
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_EXEC;
               end
            end else begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = bls_pkg::RES_DATA;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (!stat.res_last) begin
                  // display walk continues with the next entry down
                  cmd.step = 1'b1;
                  state_in = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/bls_datapath.sv -----
module bls_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bls_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [bls_pkg::WORD_W-1:0]   req_value_in,
   input  bls_pkg::bls_cmd_type                cmd,
   output bls_pkg::bls_stat_type               stat,
   output logic [bls_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [bls_pkg::WORD_W-1:0]   rsp_value_out,
   output logic                                rsp_found,
   output logic                                rsp_last
);

   logic [bls_pkg::WORD_W-1:0]   mem [0:bls_pkg::DEPTH-1];

   logic [bls_pkg::LVL_W-1:0]    fill_ff;
   logic [bls_pkg::LVL_W-1:0]    fill_in;
   logic [bls_pkg::LVL_W-1:0]    fill_dec;
   logic [bls_pkg::PTR_W-1:0]    idx_ff;
   logic [bls_pkg::ACTION_W-1:0] action_ff;
   logic [bls_pkg::WORD_W-1:0]   key_ff;
   logic [bls_pkg::WORD_W-1:0]   rd_data_ff;

   logic [bls_pkg::STATUS_W-1:0] status_ff;
   logic [bls_pkg::WORD_W-1:0]   value_ff;
   logic                         found_ff;
   logic                         last_ff;

   assign fill_dec = fill_ff - bls_pkg::LVL_W'(1);

   always_comb begin
      fill_in = fill_ff;
      if (cmd.wr_push) begin
         fill_in = fill_ff + bls_pkg::LVL_W'(1);
      end else if (cmd.pop_dec) begin
         fill_in = fill_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // request capture and scan pointer
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         action_ff <= req_action;
         key_ff    <= req_value_in;
         idx_ff    <= fill_dec[bls_pkg::PTR_W-1:0];
      end else if (cmd.step) begin
         idx_ff <= idx_ff - bls_pkg::PTR_W'(1);
      end
   end

   // stack memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_push) begin
         mem[fill_ff[bls_pkg::PTR_W-1:0]] <= key_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         status_ff <= bls_pkg::ST_OK;
         value_ff  <= '0;
         found_ff  <= 1'b0;
         last_ff   <= 1'b1;
         case (cmd.res_sel)
            bls_pkg::RES_OVF:   status_ff <= bls_pkg::ST_OVERFLOW;
            bls_pkg::RES_UNDER: status_ff <= bls_pkg::ST_UNDERFLOW;
            bls_pkg::RES_DATA: begin
               value_ff <= rd_data_ff;
               if (action_ff == bls_pkg::ACT_DISPLAY) begin
                  last_ff <= (idx_ff == '0);
               end
            end
            bls_pkg::RES_HIT: begin
               value_ff <= key_ff;
               found_ff <= 1'b1;
            end
            bls_pkg::RES_MISS: value_ff <= key_ff;
            default: ;
         endcase
      end
   end

   assign stat.action   = action_ff;
   assign stat.empty    = (fill_ff == '0);
   assign stat.full     = (fill_ff == bls_pkg::LVL_W'(bls_pkg::DEPTH));
   assign stat.idx_zero = (idx_ff == '0);
   assign stat.match    = (rd_data_ff == key_ff);
   assign stat.res_last = last_ff;

   assign rsp_status    = status_ff;
   assign rsp_value_out = value_ff;
   assign rsp_found     = found_ff;
   assign rsp_last      = last_ff;

endmodule

// ----- src/bounded_lifo_stack_unit.sv -----
// Push, and pop, display or search on an empty stack: execute, then response.
// Other pops: execute, memory fetch, response. Display: each entry from the
// top down, the next one fetched once the previous response is taken. Search:
// fetch from the top down until a match or the bottom entry. One request at a
// time; the next one is taken the cycle after the final response leaves.
// Reset (synchronous, active high) empties the stack; entries are not cleared.
module bounded_lifo_stack_unit (
   input  logic     clock,
   input  logic     reset,
   bls_req_if.sink  req_if,
   bls_rsp_if.source rsp_if
);

   bls_pkg::bls_cmd_type  cmd;
   bls_pkg::bls_stat_type stat;

   // Sequencer: steps each request through execute, memory fetch if needed and
   // response hand-off. Display and search revisit execute once per entry.
   bls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: stack memory with one write and one registered read port,
   // fill level, scan pointer, key compare and the response register.
   bls_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_if.action),
      .req_value_in  (req_if.value_in),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_if.status),
      .rsp_value_out (rsp_if.value_out),
      .rsp_found     (rsp_if.found),
      .rsp_last      (rsp_if.last)
   );

endmodule
